### sv/tfb_pkg.sv
// Package for the two-reader fanout buffer: sizes, mode codes, result record
// and pointer helpers shared by the front, queue and back modules.
// No dependencies.
package tfb_pkg;

  // Ring store geometry
  localparam int unsigned TFB_DEPTH = 4096;
  localparam int unsigned PTR_W     = $clog2(TFB_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(TFB_DEPTH - 1);

  // Field widths
  localparam int unsigned MODE_W = 2;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WAIT_W = 12;

  // Result queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QIDX_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Mode codes carried on the input channel
  localparam logic [MODE_W-1:0] MODE_PUSH        = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TAKE_FIRST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TAKE_SECOND = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] data_out;
    logic              ok;
    logic [WAIT_W-1:0] first_waiting;
    logic [WAIT_W-1:0] second_waiting;
  } res_t;

  // Front to queue: one finished result per cycle at most
  typedef struct packed {
    logic valid;
    res_t res;
  } res_push_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    res_t res;
  } q_head_t;

  // Advance a ring pointer with wrap
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  // Unread bytes between a read pointer and the write pointer
  function automatic logic [PTR_W-1:0] ptr_dist(input logic [PTR_W-1:0] w,
                                                input logic [PTR_W-1:0] r);
    logic [PTR_W:0] diff;
    diff = {1'b0, w} - {1'b0, r};
    if (w < r) begin
      diff = diff + (PTR_W+1)'(TFB_DEPTH);
    end
    return diff[PTR_W-1:0];
  endfunction

endpackage

### sv/tfb_if.sv
// Handshake channels of the two-reader fanout buffer: input items and results.
// Depends on tfb_pkg.
interface tfb_in_if
  import tfb_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [BYTE_W-1:0] data_in;
  logic              first_present;
  logic              second_present;

  modport source (output valid, mode, data_in, first_present, second_present,
                  input ready);
  modport sink   (input valid, mode, data_in, first_present, second_present,
                  output ready);
endinterface

interface tfb_out_if
  import tfb_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_out;
  logic              ok;
  logic [WAIT_W-1:0] first_waiting;
  logic [WAIT_W-1:0] second_waiting;

  modport source (output valid, data_out, ok, first_waiting, second_waiting,
                  input ready);
  modport sink   (input valid, data_out, ok, first_waiting, second_waiting,
                  output ready);
endinterface

### sv/tfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tfb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/tfb_front.sv
// Front end: accepts items while the queue has room, classifies them,
// updates the ring pointers and drives the byte store; hands one finished
// result a cycle to the queue. Depends on tfb_pkg, tfb_if and tfb_ram.
module tfb_front
  import tfb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  tfb_in_if.sink           in_ch,
  input  logic [QCNT_W-1:0] q_count,
  output res_push_t        res_push
);

  logic [PTR_W-1:0]  wp_r, wp_nxt;
  logic [PTR_W-1:0]  rp1_r, rp1_nxt;
  logic [PTR_W-1:0]  rp2_r, rp2_nxt;
  logic [PTR_W-1:0]  unread1, unread2, held1, held2, held;
  logic              in_fire;
  logic              ram_we, ram_re;
  logic [PTR_W-1:0]  ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic              ok_nxt, take_nxt;
  logic [QCNT_W:0]   slots_used;

  logic              s1_valid_r;
  logic              s1_take_r;
  logic              s1_ok_r;
  logic [WAIT_W-1:0] s1_w1_r;
  logic [WAIT_W-1:0] s1_w2_r;

  // Accept only while the queue has room for everything in flight
  assign slots_used  = {1'b0, q_count} + (QCNT_W+1)'(s1_valid_r);
  assign in_ch.ready = (slots_used < (QCNT_W+1)'(QDEPTH));
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Fill levels of both readers and the fullest attached one
  always_comb begin
    unread1 = ptr_dist(wp_r, rp1_r);
    unread2 = ptr_dist(wp_r, rp2_r);
    held1   = in_ch.first_present  ? unread1 : '0;
    held2   = in_ch.second_present ? unread2 : '0;
    held    = (held2 > held1) ? held2 : held1;
  end

  // Classify the item and work out pointer moves and the store access
  always_comb begin
    wp_nxt    = wp_r;
    rp1_nxt   = rp1_r;
    rp2_nxt   = rp2_r;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = rp1_r;
    ok_nxt    = 1'b0;
    take_nxt  = 1'b0;
    if (in_fire) begin
      unique case (in_ch.mode)
        MODE_PUSH: begin
          if (in_ch.first_present || in_ch.second_present) begin
            if (!in_ch.first_present) begin
              rp1_nxt = wp_r;
            end
            if (!in_ch.second_present) begin
              rp2_nxt = wp_r;
            end
            if (held < PTR_LAST) begin
              ram_we = 1'b1;
              wp_nxt = ptr_inc(wp_r);
              ok_nxt = 1'b1;
            end
          end
        end
        MODE_TAKE_FIRST: begin
          take_nxt = 1'b1;
          if (unread1 != '0) begin
            ram_re  = 1'b1;
            rp1_nxt = ptr_inc(rp1_r);
            ok_nxt  = 1'b1;
          end
        end
        MODE_TAKE_SECOND: begin
          take_nxt  = 1'b1;
          ram_raddr = rp2_r;
          if (unread2 != '0) begin
            ram_re  = 1'b1;
            rp2_nxt = ptr_inc(rp2_r);
            ok_nxt  = 1'b1;
          end
        end
        default: begin
          // unused code: result only, no state change
        end
      endcase
    end
  end

  // Pointer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp1_r <= '0;
      rp2_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp1_r <= rp1_nxt;
      rp2_r <= rp2_nxt;
    end
  end

  // Hold the item's outcome while the store read completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_take_r <= take_nxt;
      s1_ok_r   <= ok_nxt;
      s1_w1_r   <= WAIT_W'(ptr_dist(wp_nxt, rp1_nxt));
      s1_w2_r   <= WAIT_W'(ptr_dist(wp_nxt, rp2_nxt));
    end
  end

  tfb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TFB_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (in_ch.data_in),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Form the result; only a successful take carries a byte
  always_comb begin
    res_push.valid              = s1_valid_r;
    res_push.res.data_out       = (s1_take_r && s1_ok_r) ? ram_rdata : '0;
    res_push.res.ok             = s1_ok_r;
    res_push.res.first_waiting  = s1_w1_r;
    res_push.res.second_waiting = s1_w2_r;
  end

endmodule

### sv/tfb_queue.sv
// Short result queue between front and back end; lets each side stall alone.
// Depends on tfb_pkg.
module tfb_queue
  import tfb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  res_push_t         res_push,
  input  logic              pop,
  output q_head_t           q_head,
  output logic [QCNT_W-1:0] q_count
);

  res_t              slot_r [QDEPTH];
  logic [QIDX_W-1:0] head_r, head_nxt;
  logic [QIDX_W-1:0] tail_r, tail_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_pop;

  function automatic logic [QIDX_W-1:0] idx_inc(input logic [QIDX_W-1:0] i);
    return (i == QIDX_W'(QDEPTH - 1)) ? '0 : i + QIDX_W'(1);
  endfunction

  assign do_pop = pop && (cnt_r != '0);

  // Advance head, tail and fill count
  always_comb begin
    head_nxt = do_pop ? idx_inc(head_r) : head_r;
    tail_nxt = res_push.valid ? idx_inc(tail_r) : tail_r;
    cnt_nxt  = cnt_r;
    if (res_push.valid && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!res_push.valid && do_pop) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Store incoming results
  always_ff @(posedge clk) begin
    if (res_push.valid) begin
      slot_r[tail_r] <= res_push.res;
    end
  end

  assign q_head.valid = (cnt_r != '0);
  assign q_head.res   = slot_r[head_r];
  assign q_count      = cnt_r;

endmodule

### sv/tfb_back.sv
// Back end: output register that presents queued results on the out channel.
// Depends on tfb_pkg and tfb_if.
module tfb_back
  import tfb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  q_head_t   q_head,
  output logic      pop,
  tfb_out_if.source out_ch
);

  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  // Load the register when it is empty or being emptied
  assign pop = q_head.valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res_r <= q_head.res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.data_out       = out_res_r.data_out;
  assign out_ch.ok             = out_res_r.ok;
  assign out_ch.first_waiting  = out_res_r.first_waiting;
  assign out_ch.second_waiting = out_res_r.second_waiting;

endmodule

### sv/two_reader_fanout_buffer.sv
// Channel  | Dir | Carries
// in_ch    | in  | mode, data_in, first_present, second_present (valid/ready)
// out_ch   | out | data_out, ok, first_waiting, second_waiting (valid/ready)
//
// One item per cycle sustained while the result queue has room; each result
// follows its accepted item through pointer update and store access, the store
// read register, the queue and the output register. Each item makes at most
// one store access, a write or a read.
// Reset clears all pointers, the queue and the output register; the store
// itself is not cleared. Input stalls only when the four-entry result queue
// is committed; output stalls back up into the queue.
//
// Top level of the two-reader fanout buffer. Depends on tfb_pkg, tfb_if,
// tfb_front, tfb_queue and tfb_back.
module two_reader_fanout_buffer
  import tfb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  tfb_in_if.sink    in_ch,
  tfb_out_if.source out_ch
);

  res_push_t         res_push;
  q_head_t           q_head;
  logic              q_pop;
  logic [QCNT_W-1:0] q_count;

  tfb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_count  (q_count),
    .res_push (res_push)
  );

  tfb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .pop      (q_pop),
    .q_head   (q_head),
    .q_count  (q_count)
  );

  tfb_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_head (q_head),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

  // Queue fill never passes its depth
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= QCNT_W'(QDEPTH))
    else $error("result queue overfilled");

  // Front never pushes into a full queue
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res_push.valid |-> (q_count < QCNT_W'(QDEPTH)))
    else $error("push into full result queue");

  // A refused item carries no byte
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ok) |-> (out_ch.data_out == '0))
    else $error("refused result carries data");

  // An accepted item always yields a push into the queue on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> res_push.valid)
    else $error("accepted item lost");

endmodule

### tb/sv/tfb_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the two-reader fanout buffer: watches both channels, keeps its
// own copy of the ring and pointers, and compares every result transaction in order.
// Depends on tfb_pkg and tfb_if.
module tfb_result_checker
  import tfb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  tfb_in_if    in_mon,
  tfb_out_if   out_mon,
  output int   mismatches,
  output int   expected_left
);

  // Shadow ring and pointers
  logic [BYTE_W-1:0] shadow_ring [TFB_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_first;
  logic [PTR_W-1:0]  rd_second;

  // Results still owed by the block, oldest first
  res_t owed_results [$];

  function automatic int unread_of(input logic [PTR_W-1:0] rp);
    return (int'(wr_ptr) - int'(rp) + int'(TFB_DEPTH)) % int'(TFB_DEPTH);
  endfunction

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (int'(p) == int'(TFB_DEPTH) - 1) ? '0 : p + 1'b1;
  endfunction

  // Apply one transaction to the shadow state and return the result it owes
  function automatic res_t fanout_step(input logic [MODE_W-1:0] m,
                                       input logic [BYTE_W-1:0] d,
                                       input logic fp, input logic sp);
    res_t r;
    int   fullest;
    r = '0;
    fullest = 0;
    case (m)
      MODE_PUSH: begin
        if (fp || sp) begin
          // snap absent readers, then gate on the fullest attached one
          if (!fp) rd_first = wr_ptr;
          else fullest = unread_of(rd_first);
          if (!sp) rd_second = wr_ptr;
          else if (unread_of(rd_second) > fullest) fullest = unread_of(rd_second);
          if (fullest < int'(TFB_DEPTH) - 1) begin
            shadow_ring[wr_ptr] = d;
            wr_ptr = wrap_inc(wr_ptr);
            r.ok = 1'b1;
          end
        end
      end
      MODE_TAKE_FIRST: begin
        if (unread_of(rd_first) != 0) begin
          r.data_out = shadow_ring[rd_first];
          r.ok = 1'b1;
          rd_first = wrap_inc(rd_first);
        end
      end
      MODE_TAKE_SECOND: begin
        if (unread_of(rd_second) != 0) begin
          r.data_out = shadow_ring[rd_second];
          r.ok = 1'b1;
          rd_second = wrap_inc(rd_second);
        end
      end
      default: begin
      end
    endcase
    r.first_waiting  = WAIT_W'(unread_of(rd_first));
    r.second_waiting = WAIT_W'(unread_of(rd_second));
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Predict on accepted input first, so a same-edge result still finds its entry
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      wr_ptr = '0;
      rd_first = '0;
      rd_second = '0;
      owed_results.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        owed_results.push_back(fanout_step(in_mon.mode, in_mon.data_in,
                                           in_mon.first_present, in_mon.second_present));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch("result with nothing outstanding", 1, 0);
        end else begin
          want = owed_results.pop_front();
          if (out_mon.data_out !== want.data_out)
            report_mismatch("data_out", out_mon.data_out, want.data_out);
          if (out_mon.ok !== want.ok)
            report_mismatch("ok", out_mon.ok, want.ok);
          if (out_mon.first_waiting !== want.first_waiting)
            report_mismatch("first_waiting", out_mon.first_waiting, want.first_waiting);
          if (out_mon.second_waiting !== want.second_waiting)
            report_mismatch("second_waiting", out_mon.second_waiting, want.second_waiting);
        end
      end
    end
    expected_left = owed_results.size();
  end

endmodule

### tb/sv/two_reader_fanout_buffer_test.sv
`timescale 1ns / 100ps
// Top of the two-reader fanout buffer regression: clock, reset, push/take stimulus,
// result back-pressure and the verdict. Depends on tfb_pkg, tfb_if,
// two_reader_fanout_buffer and tfb_result_checker.
module two_reader_fanout_buffer_test;
  import tfb_pkg::*;

  // Mode value with no meaning; the block must ignore it
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS  = 1550;
  localparam int FILL_PUSHES   = TFB_DEPTH + 2;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 8;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   expected_left;
  bit   send_burst;
  bit   take_burst;

  tfb_in_if  in_ch ();
  tfb_out_if out_ch ();

  two_reader_fanout_buffer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tfb_result_checker result_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .mismatches    (mismatches),
    .expected_left (expected_left)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Offer one transaction from a falling edge; return on the falling edge after it
  task automatic offer(input logic [MODE_W-1:0] m, input logic [BYTE_W-1:0] d,
                       input logic fp, input logic sp);
    int gap;
    if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.mode = m;
    in_ch.data_in = d;
    in_ch.first_present = fp;
    in_ch.second_present = sp;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    in_ch.valid = 1'b0;
    while (expected_left != 0) @(negedge clk);
  endtask

  // Result side: random stalls, plus a long hold-off now and then
  initial begin
    int gap;
    int taken;
    taken = 0;
    take_burst = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) take_burst = !take_burst;
      gap = take_burst ? 0 : $urandom_range(0, 3);
      if (taken % 2000 == 100) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
      @(negedge clk);
    end
  end

  // Reset, directed cases, one full-ring pass, then random traffic
  initial begin
    int pick;
    int who;
    logic fp;
    logic sp;
    rst_n = 1'b0;
    send_burst = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_PUSH;
    in_ch.data_in = '0;
    in_ch.first_present = 1'b0;
    in_ch.second_present = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // empty takes, ignored mode, push with no reader attached
    offer(MODE_TAKE_FIRST, 8'h00, 1'b1, 1'b1);
    offer(MODE_TAKE_SECOND, 8'hFF, 1'b1, 1'b1);
    offer(MODE_UNUSED, 8'hFF, 1'b1, 1'b1);
    offer(MODE_PUSH, 8'hAA, 1'b0, 1'b0);
    // stores with both, then each reader alone (the absent one snaps)
    offer(MODE_PUSH, 8'h00, 1'b1, 1'b1);
    offer(MODE_PUSH, 8'hFF, 1'b1, 1'b1);
    offer(MODE_PUSH, 8'h5A, 1'b1, 1'b0);
    offer(MODE_PUSH, 8'hA5, 1'b0, 1'b1);
    offer(MODE_PUSH, 8'h81, 1'b1, 1'b1);
    // takes ignore the presence flags and never snap
    offer(MODE_TAKE_FIRST, 8'h00, 1'b0, 1'b0);
    offer(MODE_TAKE_SECOND, 8'h00, 1'b0, 1'b0);
    offer(MODE_TAKE_SECOND, 8'hFF, 1'b1, 1'b0);
    offer(MODE_TAKE_SECOND, 8'h00, 1'b0, 1'b1);
    offer(MODE_TAKE_FIRST, 8'h00, 1'b1, 1'b1);
    offer(MODE_UNUSED, 8'h00, 1'b0, 1'b0);
    wait_for_drain();

    // fill the first reader to the brim and wrap the write pointer
    for (int n = 0; n < FILL_PUSHES; n++) begin
      offer(MODE_PUSH, BYTE_W'($urandom), 1'b1, 1'b0);
    end
    // first reader full: refused with both attached, and the second still snaps alone
    offer(MODE_PUSH, 8'hFF, 1'b1, 1'b1);
    offer(MODE_PUSH, 8'h00, 1'b1, 1'b0);
    // drop the first reader: it snaps and the byte goes in
    offer(MODE_PUSH, 8'h3C, 1'b0, 1'b1);
    for (int n = 0; n < 4; n++) begin
      offer(MODE_PUSH, BYTE_W'($urandom), 1'b1, 1'b1);
      offer(MODE_TAKE_FIRST, 8'h00, 1'b0, 1'b0);
      offer(MODE_TAKE_SECOND, 8'h00, 1'b0, 1'b0);
    end

    // random traffic, mostly attached pushes and takes
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) wait_for_drain();
      pick = $urandom_range(0, 99);
      who = $urandom_range(0, 99);
      fp = (who < 78) || (who >= 96 && $urandom_range(0, 1) == 1);
      sp = (who < 60) || (who >= 78 && who < 96);
      if (who >= 96) begin
        fp = 1'b0;
        sp = 1'b0;
      end
      if (pick < 45) offer(MODE_PUSH, BYTE_W'($urandom), fp, sp);
      else if (pick < 72) offer(MODE_TAKE_FIRST, BYTE_W'($urandom), fp, sp);
      else if (pick < 97) offer(MODE_TAKE_SECOND, BYTE_W'($urandom), fp, sp);
      else offer(MODE_UNUSED, BYTE_W'($urandom), fp, sp);
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_left == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
